// ===== design/gclp_pkg.sv =====
// shared types, constants and helper functions of the g-code line parser
package gclp_pkg;

  localparam int DEF_MAX_DIGITS = 16;
  localparam int FRAC_DIGITS    = 4;

  localparam int N_ARGS  = 14;
  localparam int IDX_W   = 4;
  localparam int MAG_W   = 32;
  localparam int NUM_W   = 16;
  localparam int FRAC_W  = 3;
  localparam int POW_W   = 20;
  localparam int PROD_W  = MAG_W + POW_W;

  localparam logic [MAG_W-1:0] MAG_CAP = 32'h8000_0000;
  localparam logic [MAG_W-1:0] POS_MAX = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // argument letters in field index order S P X Y Z I J D H F R Q E N
  localparam logic [7:0] ARG_LETTERS [N_ARGS] = '{
    8'h53, 8'h50, 8'h58, 8'h59, 8'h5A, 8'h49, 8'h4A,
    8'h44, 8'h48, 8'h46, 8'h52, 8'h51, 8'h45, 8'h4E
  };

  typedef struct packed {
    logic latch;
    logic take;
    logic is_arg;
    logic clr_num;
    logic set_kind;
    logic clr_args;
    logic set_letter;
    logic set_number;
    logic mul;
    logic store;
    logic run_push;
    logic err_load;
  } gclp_cmd_t;

  typedef struct packed {
    logic is_g;
    logic is_m;
    logic is_nl;
    logic is_sp;
    logic is_semi;
    logic is_num;
    logic letter_hit;
    logic dc_zero;
    logic dc_full;
    logic run_last;
    logic out_free;
  } gclp_sts_t;

  function automatic logic [POW_W-1:0] pow10_f(input logic [FRAC_W-1:0] n);
    logic [POW_W-1:0] p;
    case (n)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== design/gclp_in_if.sv =====
// byte input channel of the g-code line parser
interface gclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

// ===== design/gclp_out_if.sv =====
// result channel of the g-code line parser
interface gclp_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               command_kind;
  logic signed [15:0] command_number;
  logic        [3:0]  field_index;
  logic signed [31:0] field_value;
  logic               last;

  modport source (output valid, output status, output command_kind, output command_number,
                  output field_index, output field_value, output last, input ready);
  modport sink   (input valid, input status, input command_kind, input command_number,
                  input field_index, input field_value, input last, output ready);
endinterface

// ===== design/gclp_dp.sv =====
// parser datapath: byte register, number accumulator, argument registers, result register
module gclp_dp
  import gclp_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              char_in,
  input  gclp_cmd_t               cmd,
  output gclp_sts_t               sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_status,
  output logic                    out_kind,
  output logic signed [NUM_W-1:0] out_number,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [MAG_W-1:0] out_value,
  output logic                    out_last
);

  localparam int DigW = $clog2(MAX_DIGITS);
  localparam logic [DigW-1:0] DIG_LIMIT = DigW'(MAX_DIGITS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_ARGS - 1);
  localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(FRAC_DIGITS);

  logic [7:0]        char_r;
  logic              kind_r, kind_nxt;
  logic [NUM_W-1:0]  number_r, number_nxt;
  logic [IDX_W-1:0]  letter_r, letter_nxt;
  logic [MAG_W-1:0]  acc_r, acc_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic              neg_r, neg_nxt;
  logic              dot_r, dot_nxt;
  logic              stop_r, stop_nxt;
  logic [DigW-1:0]   dc_r, dc_nxt;
  logic [MAG_W-1:0]  args_r [N_ARGS];
  logic [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]  run_idx_r, run_idx_nxt;
  logic              out_valid_r;

  logic              is_digit;
  logic [3:0]        digit;
  logic [MAG_W+3:0]  acc_ext, acc_step;
  logic [MAG_W-1:0]  acc_sat;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [FRAC_W-1:0] shift;
  logic [MAG_W-1:0]  prod_sat, arg_val;
  logic [NUM_W-1:0]  cmd_val;

  assign is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign digit    = 4'(char_r - CH_ZERO);
  assign acc_ext  = {4'b0, acc_r};
  assign acc_step = (acc_ext << 3) + (acc_ext << 1) + {{MAG_W{1'b0}}, digit};
  assign acc_sat  = (acc_step > {4'b0, MAG_CAP}) ? MAG_CAP : acc_step[MAG_W-1:0];

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < N_ARGS; k++) begin
      if (ARG_LETTERS[k] == char_r) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(k);
      end
    end
  end

  // command number clamps to the 16-bit signed range
  always_comb begin
    if (neg_r) begin
      cmd_val = (acc_r > 32'd32768) ? 16'h8000 : 16'(32'd0 - acc_r);
    end else begin
      cmd_val = (acc_r > 32'd32767) ? 16'h7FFF : acc_r[NUM_W-1:0];
    end
  end

  assign shift    = (frac_r < FRAC_MAX) ? FRAC_MAX - frac_r : '0;
  assign prod_sat = (prod_r > {{POW_W{1'b0}}, MAG_CAP}) ? MAG_CAP : prod_r[MAG_W-1:0];
  assign arg_val  = neg_r ? (32'd0 - prod_sat) : ((prod_sat > POS_MAX) ? POS_MAX : prod_sat);

  // number accumulator
  always_comb begin
    acc_nxt  = acc_r;
    frac_nxt = frac_r;
    neg_nxt  = neg_r;
    dot_nxt  = dot_r;
    stop_nxt = stop_r;
    dc_nxt   = dc_r;
    if (cmd.clr_num) begin
      acc_nxt  = '0;
      frac_nxt = '0;
      neg_nxt  = 1'b0;
      dot_nxt  = 1'b0;
      stop_nxt = 1'b0;
      dc_nxt   = '0;
    end else if (cmd.take) begin
      dc_nxt = dc_r + 1'b1;
      if (!stop_r) begin
        if (char_r == CH_MINUS) begin
          if (dc_r == '0) neg_nxt = 1'b1;
          else stop_nxt = 1'b1;
        end else if (char_r == CH_DOT) begin
          if (cmd.is_arg && !dot_r) dot_nxt = 1'b1;
          else stop_nxt = 1'b1;
        end else if (dot_r) begin
          if (frac_r < FRAC_MAX) begin
            acc_nxt  = acc_sat;
            frac_nxt = frac_r + 1'b1;
          end
        end else begin
          acc_nxt = acc_sat;
        end
      end
    end
  end

  assign kind_nxt    = cmd.set_kind ? (char_r == CH_M) : kind_r;
  assign number_nxt  = cmd.set_number ? cmd_val : number_r;
  assign letter_nxt  = cmd.set_letter ? hit_idx : letter_r;
  assign run_idx_nxt = cmd.run_push ? ((run_idx_r == LAST_IDX) ? '0 : run_idx_r + 1'b1)
                                    : run_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= 1'b0;
      number_r    <= '0;
      letter_r    <= '0;
      acc_r       <= '0;
      frac_r      <= '0;
      neg_r       <= 1'b0;
      dot_r       <= 1'b0;
      stop_r      <= 1'b0;
      dc_r        <= '0;
      run_idx_r   <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < N_ARGS; k++) args_r[k] <= '0;
    end else begin
      kind_r    <= kind_nxt;
      number_r  <= number_nxt;
      letter_r  <= letter_nxt;
      acc_r     <= acc_nxt;
      frac_r    <= frac_nxt;
      neg_r     <= neg_nxt;
      dot_r     <= dot_nxt;
      stop_r    <= stop_nxt;
      dc_r      <= dc_nxt;
      run_idx_r <= run_idx_nxt;
      if (cmd.run_push || cmd.err_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      // a run hands each argument out once and leaves it zero
      if (cmd.clr_args) begin
        for (int k = 0; k < N_ARGS; k++) args_r[k] <= '0;
      end else if (cmd.store) begin
        args_r[letter_r] <= arg_val;
      end else if (cmd.run_push) begin
        args_r[run_idx_r] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) char_r <= char_in;
    if (cmd.mul) prod_r <= {{POW_W{1'b0}}, acc_r} * {{MAG_W{1'b0}}, pow10_f(shift)};
    if (cmd.run_push) begin
      out_status <= 1'b0;
      out_kind   <= kind_r;
      out_number <= number_r;
      out_index  <= run_idx_r;
      out_value  <= args_r[run_idx_r];
      out_last   <= (run_idx_r == LAST_IDX);
    end else if (cmd.err_load) begin
      out_status <= 1'b1;
      out_kind   <= 1'b0;
      out_number <= '0;
      out_index  <= '0;
      out_value  <= '0;
      out_last   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.is_g       = (char_r == CH_G);
  assign sts.is_m       = (char_r == CH_M);
  assign sts.is_nl      = (char_r == CH_NL);
  assign sts.is_sp      = (char_r == CH_SPACE);
  assign sts.is_semi    = (char_r == CH_SEMI);
  assign sts.is_num     = is_digit || (char_r == CH_DOT) || (char_r == CH_MINUS);
  assign sts.letter_hit = hit;
  assign sts.dc_zero    = (dc_r == '0);
  assign sts.dc_full    = (dc_r >= DIG_LIMIT);
  assign sts.run_last   = (run_idx_r == LAST_IDX);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== design/gclp_ctrl.sv =====
// parser controller: parse phase and sequencing of byte, store, run and error steps
module gclp_ctrl
  import gclp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gclp_sts_t sts,
  output gclp_cmd_t cmd
);

  localparam logic [2:0] PH_WAIT_NL = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_CMD_NUM = 3'd2;
  localparam logic [2:0] PH_ARG     = 3'd3;
  localparam logic [2:0] PH_ARG_NUM = 3'd4;

  localparam logic [2:0] ST_IN    = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IN);

  always_comb begin
    cmd       = '0;
    phase_nxt = phase_r;
    state_nxt = state_r;
    unique case (state_r)
      ST_IN: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IN;
        unique case (phase_r)
          PH_CMD: begin
            if (sts.is_g || sts.is_m) begin
              cmd.clr_args = 1'b1;
              cmd.set_kind = 1'b1;
              phase_nxt    = PH_CMD_NUM;
            end else if (!sts.is_nl) begin
              phase_nxt = PH_WAIT_NL;
            end
          end
          PH_CMD_NUM: begin
            if (sts.is_sp || sts.is_nl) begin
              if (sts.dc_zero) begin
                if (sts.is_sp) state_nxt = ST_ERR;
              end else begin
                cmd.set_number = 1'b1;
                cmd.clr_num    = 1'b1;
                if (sts.is_sp) begin
                  phase_nxt = PH_ARG;
                end else begin
                  phase_nxt = PH_CMD;
                  state_nxt = ST_RUN;
                end
              end
            end else if (!sts.is_num || sts.dc_full) begin
              state_nxt = ST_ERR;
            end else begin
              cmd.take = 1'b1;
            end
          end
          PH_ARG: begin
            if (sts.letter_hit) begin
              cmd.set_letter = 1'b1;
              phase_nxt      = PH_ARG_NUM;
            end else if (sts.is_semi || sts.is_sp) begin
              cmd.clr_num = 1'b1;
              phase_nxt   = PH_WAIT_NL;
              state_nxt   = ST_RUN;
            end else begin
              state_nxt = ST_ERR;
            end
          end
          PH_ARG_NUM: begin
            if (sts.is_sp) begin
              if (sts.dc_zero) begin
                state_nxt = ST_ERR;
              end else begin
                cmd.mul   = 1'b1;
                phase_nxt = PH_ARG;
                state_nxt = ST_STORE;
              end
            end else if (sts.is_nl || sts.is_semi) begin
              if (!sts.dc_zero) begin
                cmd.mul   = 1'b1;
                phase_nxt = sts.is_nl ? PH_CMD : PH_WAIT_NL;
                state_nxt = ST_STORE;
              end
            end else if (!sts.is_num || sts.dc_full) begin
              state_nxt = ST_ERR;
            end else begin
              cmd.take   = 1'b1;
              cmd.is_arg = 1'b1;
            end
          end
          default: begin
            phase_nxt = sts.is_nl ? PH_CMD : PH_WAIT_NL;
          end
        endcase
        if (state_nxt == ST_ERR) begin
          cmd.clr_num = 1'b1;
          phase_nxt   = PH_WAIT_NL;
        end
      end
      ST_STORE: begin
        cmd.store   = 1'b1;
        cmd.clr_num = 1'b1;
        // a space leads on to the next argument, a line end or ';' finishes the command
        state_nxt   = (phase_r == PH_ARG) ? ST_IN : ST_RUN;
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.run_push = 1'b1;
          if (sts.run_last) state_nxt = ST_IN;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.err_load = 1'b1;
          state_nxt    = ST_IN;
        end
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_NL;
      state_r <= ST_IN;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/gcode_line_parser_core.sv =====
// top level of the byte-serial g-code line parser
// in_ch carries one text byte per item (char_in); out_ch carries parsed results.
// each byte is taken in, then decoded and used to update the accumulator; the
// block accepts no new byte until the last one has been decoded.
// a space, newline or ';' that closes an argument value also starts the scaling
// multiply (value times a power of ten) and adds a store step for the argument write.
// a finished command yields a run of fourteen items, one per argument letter in
// the order S P X Y Z I J D H F R Q E N, with last set on the final one; the run
// moves at one item per cycle while out_ch.ready is high. a malformed command
// yields one item with status and last set, and bytes up to the next newline are
// skipped. results go through a single output register: the next byte is taken
// while the last item waits, but no new item is loaded until the held one leaves,
// so a stalled receiver stops the byte input once another result is due.
// reset (rst_n low, synchronous) empties the output register, clears all argument
// values and skips text up to the first newline.
module gcode_line_parser_core
  import gclp_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic clk,
  input  logic rst_n,
  gclp_in_if.sink    in_ch,
  gclp_out_if.source out_ch
);

  gclp_cmd_t cmd;
  gclp_sts_t sts;

  gclp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gclp_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_in    (in_ch.char_in),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_kind   (out_ch.command_kind),
    .out_number (out_ch.command_number),
    .out_index  (out_ch.field_index),
    .out_value  (out_ch.field_value),
    .out_last   (out_ch.last)
  );

endmodule

// ===== tb/gclp_checker.sv =====
// checker of the g-code line parser: predicts result items from accepted bytes and compares
module gclp_checker
  import gclp_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic clk,
  input  logic rst_n,
  gclp_in_if   in_ch,
  gclp_out_if  out_ch,
  output int   fail_count,
  output int   pending_count,
  output int   runs_predicted,
  output int   errors_predicted
);

  typedef enum logic [2:0] {
    ST_WAIT_NL,
    ST_CMD,
    ST_CMD_NUM,
    ST_ARG,
    ST_ARG_NUM
  } parse_state_e;

  typedef struct packed {
    logic               status;
    logic               kind;
    logic signed [15:0] number;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] value;
    logic               last;
  } parse_result_t;

  parse_state_e     state_q;
  logic             kind_q;
  logic [15:0]      cmd_number_q;
  logic [IDX_W-1:0] letter_q;
  logic [31:0]      mag_q;
  int               frac_q;
  logic             neg_q;
  logic             dot_q;
  logic             stop_q;
  int               count_q;
  logic [31:0]      arg_vals [N_ARGS];

  parse_result_t expected_results [$];

  function automatic logic [31:0] clamp_magnitude(input logic [63:0] v);
    return (v > {32'd0, MAG_CAP}) ? MAG_CAP : v[31:0];
  endfunction

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] p;
    p = 64'd1;
    repeat (n) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic void clear_number();
    mag_q   = '0;
    frac_q  = 0;
    neg_q   = 1'b0;
    dot_q   = 1'b0;
    stop_q  = 1'b0;
    count_q = 0;
  endfunction

  function automatic void clear_arguments();
    for (int k = 0; k < N_ARGS; k++) arg_vals[k] = '0;
  endfunction

  function automatic void push_error();
    parse_result_t r;
    r        = '0;
    r.status = 1'b1;
    r.last   = 1'b1;
    expected_results.push_back(r);
    errors_predicted++;
    clear_number();
    state_q = ST_WAIT_NL;
  endfunction

  function automatic void push_run();
    parse_result_t r;
    for (int k = 0; k < N_ARGS; k++) begin
      r.status = 1'b0;
      r.kind   = kind_q;
      r.number = cmd_number_q;
      r.index  = IDX_W'(k);
      r.value  = arg_vals[k];
      r.last   = (k == N_ARGS - 1);
      expected_results.push_back(r);
    end
    runs_predicted++;
    clear_arguments();
    clear_number();
  endfunction

  function automatic void take_number_char(input logic [7:0] c, input logic is_arg);
    logic        first;
    logic [63:0] nxt;
    first = (count_q == 0);
    count_q++;
    if (!stop_q) begin
      if (c == CH_MINUS) begin
        if (first) neg_q = 1'b1;
        else stop_q = 1'b1;
      end else if (c == CH_DOT) begin
        if (is_arg && !dot_q) dot_q = 1'b1;
        else stop_q = 1'b1;
      end else begin
        nxt = {32'd0, mag_q} * 64'd10 + 64'(c - CH_ZERO);
        if (!dot_q) begin
          mag_q = clamp_magnitude(nxt);
        end else if (frac_q < FRAC_DIGITS) begin
          // digits past the fraction width are dropped
          mag_q = clamp_magnitude(nxt);
          frac_q++;
        end
      end
    end
  endfunction

  function automatic logic [15:0] command_code();
    logic [31:0] m;
    m = mag_q;
    if (neg_q) begin
      if (m > 32'd32768) m = 32'd32768;
      m = 32'd0 - m;
    end else if (m > 32'd32767) begin
      m = 32'd32767;
    end
    return m[15:0];
  endfunction

  function automatic logic [31:0] scaled_argument();
    int          shift;
    logic [31:0] m;
    shift = (frac_q < FRAC_DIGITS) ? FRAC_DIGITS - frac_q : 0;
    m     = clamp_magnitude({32'd0, mag_q} * ten_to(shift));
    if (neg_q) return 32'd0 - m;
    return (m > POS_MAX) ? POS_MAX : m;
  endfunction

  function automatic void store_argument();
    arg_vals[letter_q] = scaled_argument();
    clear_number();
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    logic num_ok;
    logic hit;
    num_ok = (is_digit(c) || c == CH_DOT || c == CH_MINUS) && (count_q < MAX_DIGITS - 1);
    hit    = 1'b0;
    case (state_q)
      ST_CMD: begin
        if (c == CH_G || c == CH_M) begin
          clear_arguments();
          kind_q  = (c == CH_M);
          state_q = ST_CMD_NUM;
        end else if (c != CH_NL) begin
          state_q = ST_WAIT_NL;
        end
      end
      ST_CMD_NUM: begin
        if (c == CH_SPACE || c == CH_NL) begin
          if (count_q == 0) begin
            // empty command number: space is an error, newline is ignored
            if (c == CH_SPACE) push_error();
          end else begin
            cmd_number_q = command_code();
            clear_number();
            if (c == CH_SPACE) begin
              state_q = ST_ARG;
            end else begin
              state_q = ST_CMD;
              push_run();
            end
          end
        end else if (!num_ok) begin
          push_error();
        end else begin
          take_number_char(c, 1'b0);
        end
      end
      ST_ARG: begin
        for (int k = 0; k < N_ARGS; k++) begin
          if (!hit && ARG_LETTERS[k] == c) begin
            hit      = 1'b1;
            letter_q = IDX_W'(k);
          end
        end
        if (hit) begin
          state_q = ST_ARG_NUM;
        end else if (c == CH_SEMI || c == CH_SPACE) begin
          state_q = ST_WAIT_NL;
          push_run();
        end else begin
          push_error();
        end
      end
      ST_ARG_NUM: begin
        if (c == CH_SPACE) begin
          if (count_q == 0) begin
            push_error();
          end else begin
            store_argument();
            state_q = ST_ARG;
          end
        end else if (c == CH_NL || c == CH_SEMI) begin
          if (count_q != 0) begin
            store_argument();
            state_q = (c == CH_NL) ? ST_CMD : ST_WAIT_NL;
            push_run();
          end
        end else if (!num_ok) begin
          push_error();
        end else begin
          take_number_char(c, 1'b1);
        end
      end
      default: begin
        state_q = (c == CH_NL) ? ST_CMD : ST_WAIT_NL;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic signed [63:0] exp_v,
                                 input logic signed [63:0] got_v);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d actual %0d", $time, what, exp_v, got_v);
  endtask

  initial begin
    fail_count       = 0;
    runs_predicted   = 0;
    errors_predicted = 0;
  end

  always @(posedge clk) begin
    parse_result_t e;
    if (!rst_n) begin
      state_q      = ST_WAIT_NL;
      kind_q       = 1'b0;
      cmd_number_q = '0;
      letter_q     = '0;
      clear_number();
      clear_arguments();
      expected_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.char_in);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result item with none expected: status %0b index %0d value %0d",
                   $time, out_ch.status, out_ch.field_index, out_ch.field_value);
        end else begin
          e = expected_results.pop_front();
          if (out_ch.status !== e.status)
            report_mismatch("status", e.status, out_ch.status);
          if (out_ch.command_kind !== e.kind)
            report_mismatch("command_kind", e.kind, out_ch.command_kind);
          if (out_ch.command_number !== e.number)
            report_mismatch("command_number", e.number, out_ch.command_number);
          if (out_ch.field_index !== e.index)
            report_mismatch("field_index", e.index, out_ch.field_index);
          if (out_ch.field_value !== e.value)
            report_mismatch("field_value", e.value, out_ch.field_value);
          if (out_ch.last !== e.last)
            report_mismatch("last", e.last, out_ch.last);
        end
      end
    end
    pending_count <= expected_results.size();
  end

endmodule

// ===== tb/gcode_line_parser_core_tb.sv =====
// top of the g-code line parser testbench: byte stimulus, receiver stalls and verdict
module gcode_line_parser_core_tb;
  import gclp_pkg::*;

  logic clk;
  logic rst_n;
  logic rx_ready = 1'b0;
  logic calm     = 1'b0;
  int   idle_odds = 0;
  int   bytes_sent = 0;
  int   fail_count;
  int   pending_count;
  int   runs_predicted;
  int   errors_predicted;
  int   hold_left = 0;

  logic [7:0] line_q [$];

  gclp_in_if  in_ch ();
  gclp_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  gcode_line_parser_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gclp_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ch            (in_ch),
    .out_ch           (out_ch),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .runs_predicted   (runs_predicted),
    .errors_predicted (errors_predicted)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("gcode_line_parser_core regression: fail");
    $finish;
  end

  // receiver: ready stretches alternate with stall bursts
  always @(posedge clk) begin
    if (calm) begin
      rx_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (rx_ready && $urandom_range(0, 2) == 0) begin
      rx_ready  <= 1'b0;
      hold_left = $urandom_range(0, 8);
    end else begin
      rx_ready  <= 1'b1;
      hold_left = $urandom_range(0, 30);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] number_char();
    int r;
    r = $urandom_range(0, 11);
    if (r == 10) return CH_DOT;
    if (r == 11) return CH_MINUS;
    return CH_ZERO + 8'(r);
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_number(input bit is_arg, input bit clean);
    int mode;
    mode = clean ? $urandom_range(0, 7) : $urandom_range(0, 9);
    case (mode)
      5: begin
        // long magnitudes to reach saturation
        if ($urandom_range(0, 1) == 0) line_q.push_back(CH_MINUS);
        add_digits($urandom_range(6, 10));
        if (is_arg && $urandom_range(0, 1) == 0) begin
          line_q.push_back(CH_DOT);
          add_digits($urandom_range(0, 3));
        end
      end
      6: repeat (DEF_MAX_DIGITS - 1) line_q.push_back(number_char());
      7: repeat ($urandom_range(1, 6)) line_q.push_back(number_char());
      8: repeat (DEF_MAX_DIGITS) line_q.push_back(number_char());
      9: if ($urandom_range(0, 1) == 0) line_q.push_back(CH_MINUS);
      default: begin
        if ($urandom_range(0, 2) == 0) line_q.push_back(CH_MINUS);
        add_digits($urandom_range(1, 4));
        if (is_arg && $urandom_range(0, 1) == 0) begin
          line_q.push_back(CH_DOT);
          add_digits($urandom_range(0, 6));
        end
      end
    endcase
  endfunction

  function automatic void build_line();
    int sel;
    sel = $urandom_range(0, 99);
    line_q.delete();
    if (sel < 88) begin
      line_q.push_back($urandom_range(0, 1) ? CH_G : CH_M);
      add_number(1'b0, sel < 75);
      repeat ($urandom_range(0, 5)) begin
        line_q.push_back(CH_SPACE);
        line_q.push_back(ARG_LETTERS[$urandom_range(0, N_ARGS - 1)]);
        add_number(1'b1, sel < 75);
      end
      case ($urandom_range(0, 7))
        0: begin
          line_q.push_back(CH_SEMI);
          repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(32, 126)));
        end
        1: line_q.push_back(CH_SPACE);
        2: begin
          line_q.push_back(CH_SPACE);
          line_q.push_back(CH_SEMI);
        end
        default: ;
      endcase
      line_q.push_back(CH_NL);
      // broken lines get one stray byte somewhere
      if (sel >= 75)
        line_q.insert($urandom_range(0, line_q.size() - 1), 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(CH_NL);
    end
  endfunction

  initial begin
    int  base;
    bit  squeezed;
    squeezed = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.char_in <= 8'h00;
    rst_n         <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: skipped text before the first newline, plain run, saturated command
    // number with extra fraction digits and ';' end, empty number, bad characters
    idle_odds = 2;
    send_text("x\n");
    send_text("G1\n");
    send_text("M99999 P-.00019;\n");
    send_text("G \n");
    send_text("G0 Q");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("\n");

    base = bytes_sent;
    while (bytes_sent - base < 420) begin
      idle_odds = $urandom_range(0, 3);
      build_line();
      foreach (line_q[i]) send_byte(line_q[i]);
      if (!squeezed && bytes_sent - base > 210) begin
        squeezed = 1'b1;
        drain();
      end
      if (bytes_sent - base > 360) calm <= 1'b1;
    end

    drain();
    repeat (40) @(posedge clk);
    $display("run covered %0d text bytes, %0d command runs and %0d parse errors",
             bytes_sent, runs_predicted, errors_predicted);
    if (fail_count == 0) begin
      $display("gcode_line_parser_core regression: pass");
    end else begin
      $display("gcode_line_parser_core regression: fail");
    end
    $finish;
  end

endmodule
